### sv/smeu_pkg.sv
// ----------------------------------------------------------------------------
// smeu_pkg
// Shared types and constants of the stack machine execute unit.
// ----------------------------------------------------------------------------
package smeu_pkg;

    localparam int STACK_DEPTH  = 64;
    localparam int RSTACK_DEPTH = 32;
    localparam int LOOP_DEPTH   = 8;
    localparam int MEM_DEPTH    = 4096;

    localparam int DP_W  = $clog2(STACK_DEPTH + 1);
    localparam int RP_W  = $clog2(RSTACK_DEPTH + 1);
    localparam int LP_W  = $clog2(LOOP_DEPTH + 1);
    localparam int DA_W  = $clog2(STACK_DEPTH);
    localparam int RA_W  = $clog2(RSTACK_DEPTH);
    localparam int LA_W  = $clog2(LOOP_DEPTH);
    localparam int MA_W  = $clog2(MEM_DEPTH);

    typedef enum logic [4:0] {
        CMD_LIT = 5'd0, CMD_ADD = 5'd1, CMD_SUB = 5'd2, CMD_MUL = 5'd3,
        CMD_DIV = 5'd4, CMD_MOD = 5'd5, CMD_EQ = 5'd6, CMD_LT = 5'd7,
        CMD_GT = 5'd8, CMD_AND = 5'd9, CMD_OR = 5'd10, CMD_NOT = 5'd11,
        CMD_DUP = 5'd12, CMD_DROP = 5'd13, CMD_SWAP = 5'd14, CMD_OVER = 5'd15,
        CMD_ROT = 5'd16, CMD_TOR = 5'd17, CMD_RFROM = 5'd18, CMD_RFETCH = 5'd19,
        CMD_STORE = 5'd20, CMD_FETCH = 5'd21, CMD_I = 5'd22, CMD_J = 5'd23,
        CMD_K = 5'd24, CMD_POPOUT = 5'd25, CMD_LENTER = 5'd26,
        CMD_LLEAVE = 5'd27
    } cmd_t;

    typedef enum logic [3:0] {
        ERR_OK = 4'd0, ERR_UNDER = 4'd1, ERR_RUNDER = 4'd2, ERR_DIV0 = 4'd3,
        ERR_ADDR = 4'd4, ERR_NOLOOP = 4'd5, ERR_OVER = 4'd6, ERR_ROVER = 4'd7,
        ERR_LOVER = 4'd8
    } err_t;

    typedef struct packed {
        logic [4:0]  cmd;
        logic signed [31:0] literal;
    } smeu_in_t;

    typedef struct packed {
        logic signed [31:0] out_value;
        logic               out_valid;
        logic [3:0]         error_code;
        logic [6:0]         depth_now;
    } smeu_out_t;

endpackage

### sv/smeu_stream_if.sv
// ----------------------------------------------------------------------------
// smeu_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface smeu_stream_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### sv/stack_machine_execute_unit_top.sv
// ----------------------------------------------------------------------------
// stack_machine_execute_unit_top
// Forth primitive execute core on Q16.16 values.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  carries one primitive (cmd, literal) per transaction.
//   out_ch carries one result (out_value, out_valid, error_code, depth_now)
//   per accepted primitive, in order.
// Timing: after acceptance, stack, memory and simple ALU primitives take
//   three registered stack reads, execute, a finish step and three
//   write-back steps before the result is offered; mul adds a second pass
//   of the split 32x16 multiplier, and div and mod run the shared restoring
//   divider, one quotient bit per cycle over 64 or 32 steps. A primitive
//   that fails its checks skips write-back before it is offered.
//   The unit takes one primitive at a time; the next one is accepted the
//   cycle after the result is loaded.
// Reset: pointers clear at once; then a clearing pass writes zero to all
//   MEM_DEPTH (4096) words of data memory, one word a cycle, while in_ch
//   stays not ready.
// Stall: the result waits in the output register while out_ch is not
//   ready; the next primitive is accepted meanwhile and runs up to its end.
// Errors leave all state unchanged.
// ----------------------------------------------------------------------------
module stack_machine_execute_unit_top (
    input  logic clk,
    input  logic rst_n,
    smeu_stream_if.sink   in_ch,
    smeu_stream_if.source out_ch
);
    import smeu_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RD0, S_RD1, S_RD2, S_EXEC, S_MUL, S_DIV,
        S_FIN, S_WB0, S_WB1, S_WB2, S_DONE
    } state_t;

    state_t state_reg;
    logic [MA_W-1:0] clr_reg;
    logic [DP_W-1:0] dp_reg;
    logic [RP_W-1:0] rp_reg;
    logic [LP_W-1:0] lp_reg;
    logic [4:0]  cmd_reg;
    logic signed [31:0] lit_reg;
    logic signed [31:0] a_reg, b_reg, c_reg, r_reg, rv_reg;
    logic [3:0] err_reg;
    logic signed [63:0] acc_reg;
    logic [6:0] cnt_reg;
    logic [63:0] rem_reg, dq_reg;
    logic [63:0] den_reg;
    logic neg_reg;
    logic out_pend_reg;
    smeu_out_t out_reg;

    logic signed [31:0] dstk [STACK_DEPTH];
    logic signed [31:0] rstk [RSTACK_DEPTH];
    logic signed [15:0] lstk [LOOP_DEPTH];
    logic signed [31:0] dmem [MEM_DEPTH];
    logic signed [31:0] drd_reg, rrd_reg, mrd_reg;
    logic signed [15:0] lrd_reg;

    // stack read address select
    logic [DA_W-1:0] drd_addr;
    logic [1:0]      rd_k;
    always_comb
    begin
        unique case (state_reg)
            S_RD0:   rd_k = 2'd0;
            S_RD1:   rd_k = 2'd1;
            default: rd_k = 2'd2;
        endcase
        drd_addr = DA_W'(dp_reg - DP_W'(1) - DP_W'(rd_k));
    end

    // operand needs and stack growth per command
    logic [1:0] need;
    logic       grow;
    always_comb
    begin
        need = 2'd0;
        grow = 1'b0;
        priority if (cmd_reg >= CMD_ADD && cmd_reg <= CMD_OR) need = 2'd2;
        else if (cmd_reg == CMD_LIT) grow = 1'b1;
        else if (cmd_reg == CMD_NOT || cmd_reg == CMD_DROP || cmd_reg == CMD_FETCH
                 || cmd_reg == CMD_POPOUT || cmd_reg == CMD_TOR) need = 2'd1;
        else if (cmd_reg == CMD_DUP) begin need = 2'd1; grow = 1'b1; end
        else if (cmd_reg == CMD_SWAP || cmd_reg == CMD_STORE) need = 2'd2;
        else if (cmd_reg == CMD_OVER) begin need = 2'd2; grow = 1'b1; end
        else if (cmd_reg == CMD_ROT) need = 2'd3;
        else if (cmd_reg == CMD_RFROM || cmd_reg == CMD_RFETCH
                 || cmd_reg == CMD_I || cmd_reg == CMD_J || cmd_reg == CMD_K)
            grow = 1'b1;
        else begin need = 2'd0; grow = 1'b0; end
    end

    // loop depth for i/j/k
    logic [1:0] ldep;
    assign ldep = (cmd_reg == CMD_I) ? 2'd1 : (cmd_reg == CMD_J) ? 2'd2 : 2'd3;

    // precondition check (all but div-zero and address)
    logic [3:0] pre_err;
    always_comb
    begin
        pre_err = ERR_OK;
        if (cmd_reg == CMD_RFROM || cmd_reg == CMD_RFETCH)
        begin
            if (rp_reg == '0) pre_err = ERR_RUNDER;
            else if (dp_reg >= DP_W'(STACK_DEPTH)) pre_err = ERR_OVER;
        end
        else if (cmd_reg == CMD_I || cmd_reg == CMD_J || cmd_reg == CMD_K)
        begin
            if (lp_reg < LP_W'(ldep)) pre_err = ERR_NOLOOP;
            else if (dp_reg >= DP_W'(STACK_DEPTH)) pre_err = ERR_OVER;
        end
        else if (cmd_reg == CMD_LENTER)
        begin
            if (lp_reg >= LP_W'(LOOP_DEPTH)) pre_err = ERR_LOVER;
        end
        else if (cmd_reg == CMD_LLEAVE)
        begin
            if (lp_reg == '0) pre_err = ERR_NOLOOP;
        end
        else if (cmd_reg == CMD_TOR)
        begin
            if (dp_reg == '0) pre_err = ERR_UNDER;
            else if (rp_reg >= RP_W'(RSTACK_DEPTH)) pre_err = ERR_ROVER;
        end
        else if (dp_reg < DP_W'(need)) pre_err = ERR_UNDER;
        else if (grow && dp_reg >= DP_W'(STACK_DEPTH)) pre_err = ERR_OVER;
    end

    // address check on top value b
    logic addr_ok;
    assign addr_ok = !b_reg[31] && ({1'b0, b_reg} < 33'(MEM_DEPTH) * 33'd65536);
    logic [MA_W-1:0] maddr;
    assign maddr = MA_W'(b_reg[31:16]);

    // shared combinational ALU for simple operations
    logic signed [32:0] sum33, dif33;
    logic signed [31:0] alu;
    logic signed [15:0] ia, ib;
    assign sum33 = 33'(a_reg) + 33'(b_reg);
    assign dif33 = 33'(a_reg) - 33'(b_reg);
    assign ia = 16'((a_reg + ((a_reg < 0) ? 32'sd65535 : 32'sd0)) >>> 16);
    assign ib = 16'((b_reg + ((b_reg < 0) ? 32'sd65535 : 32'sd0)) >>> 16);

    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        if (v > 33'sh07FFFFFFF) return 32'sh7FFFFFFF;
        if (v < -33'sh080000000) return 32'sh80000000;
        return v[31:0];
    endfunction

    always_comb
    begin
        unique case (cmd_reg)
            CMD_ADD: alu = sat33(sum33);
            CMD_SUB: alu = sat33(dif33);
            CMD_EQ:  alu = (a_reg == b_reg) ? 32'sd65536 : 32'sd0;
            CMD_LT:  alu = (a_reg <  b_reg) ? 32'sd65536 : 32'sd0;
            CMD_GT:  alu = (a_reg >  b_reg) ? 32'sd65536 : 32'sd0;
            CMD_AND: alu = {ia & ib, 16'd0};
            CMD_OR:  alu = {ia | ib, 16'd0};
            CMD_NOT: alu = (b_reg == 0) ? 32'sd65536 : 32'sd0;
            default: alu = 32'sd0;
        endcase
    end

    // magnitudes for mul/div
    logic [31:0] mag_a, mag_b;
    assign mag_a = a_reg[31] ? 32'(-a_reg) : 32'(a_reg);
    assign mag_b = b_reg[31] ? 32'(-b_reg) : 32'(b_reg);

    // saturate unsigned 64-bit magnitude with sign
    logic [63:0] mag_res;
    logic signed [31:0] sat_res;
    always_comb
    begin
        mag_res = (cmd_reg == CMD_MUL) ? 64'(acc_reg) >> 16 : dq_reg;
        if (neg_reg)
            sat_res = (mag_res > 64'h80000000) ? 32'sh80000000 : 32'(-mag_res);
        else
            sat_res = (mag_res > 64'h7FFFFFFF) ? 32'sh7FFFFFFF : 32'(mag_res);
    end

    // divider step
    logic [63:0] trial;
    assign trial = {rem_reg[62:0], dq_reg[63]};

    logic in_fire, out_fire, out_load;
    assign in_fire  = in_ch.valid && in_ch.ready;
    assign out_fire = out_ch.valid && out_ch.ready;
    assign out_load = (state_reg == S_DONE) && (!out_pend_reg || out_fire);
    assign in_ch.ready  = (state_reg == S_IDLE);
    assign out_ch.valid = out_pend_reg;
    assign out_ch.data  = out_reg;

    // memories: stacks and data memory
    always_ff @(posedge clk)
    begin
        drd_reg <= dstk[drd_addr];
        rrd_reg <= rstk[RA_W'(rp_reg - RP_W'(1))];
        lrd_reg <= lstk[LA_W'(lp_reg - LP_W'(ldep))];
        mrd_reg <= dmem[maddr];
        if (state_reg == S_CLEAR)
            dmem[clr_reg] <= 32'sd0;
        else if (state_reg == S_WB0 && cmd_reg == CMD_STORE)
            dmem[maddr] <= a_reg;
        if (state_reg == S_WB0)
        begin
            unique case (cmd_reg)
                CMD_LIT, CMD_DUP, CMD_OVER, CMD_RFROM, CMD_RFETCH,
                CMD_I, CMD_J, CMD_K:
                    dstk[DA_W'(dp_reg)] <= r_reg;
                CMD_SWAP: dstk[DA_W'(dp_reg - DP_W'(1))] <= a_reg;
                CMD_ROT:  dstk[DA_W'(dp_reg - DP_W'(3))] <= a_reg;
                CMD_FETCH: dstk[DA_W'(dp_reg - DP_W'(1))] <= mrd_reg;
                CMD_NOT:  dstk[DA_W'(dp_reg - DP_W'(1))] <= r_reg;
                default:
                    if (cmd_reg >= CMD_ADD && cmd_reg <= CMD_OR)
                        dstk[DA_W'(dp_reg - DP_W'(2))] <= r_reg;
            endcase
        end
        if (state_reg == S_WB1)
        begin
            if (cmd_reg == CMD_SWAP) dstk[DA_W'(dp_reg - DP_W'(2))] <= b_reg;
            if (cmd_reg == CMD_ROT)  dstk[DA_W'(dp_reg - DP_W'(2))] <= b_reg;
        end
        if (state_reg == S_WB2 && cmd_reg == CMD_ROT)
            dstk[DA_W'(dp_reg - DP_W'(1))] <= c_reg;
        if (state_reg == S_WB0 && cmd_reg == CMD_TOR)
            rstk[RA_W'(rp_reg)] <= b_reg;
        if (state_reg == S_WB0 && cmd_reg == CMD_LENTER)
            lstk[LA_W'(lp_reg)] <= lit_reg[15:0];
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            dp_reg       <= '0;
            rp_reg       <= '0;
            lp_reg       <= '0;
            out_pend_reg <= 1'b0;
        end
        else
        begin
            // hold a result until the receiver takes it
            if (out_load) out_pend_reg <= 1'b1;
            else if (out_fire) out_pend_reg <= 1'b0;
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + MA_W'(1);
                    if (clr_reg == MA_W'(MEM_DEPTH - 1)) state_reg <= S_IDLE;
                end
                S_IDLE:
                    if (in_fire)
                    begin
                        cmd_reg   <= in_ch.data.cmd;
                        lit_reg   <= in_ch.data.literal;
                        rv_reg    <= 32'sd0;
                        state_reg <= S_RD0;
                    end
                S_RD0:
                begin
                    // read top (b), await registered data
                    err_reg   <= pre_err;
                    state_reg <= S_RD1;
                end
                S_RD1:
                begin
                    b_reg     <= drd_reg;
                    state_reg <= S_RD2;
                end
                S_RD2:
                begin
                    a_reg     <= drd_reg;
                    state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    // third operand of rot, div-zero and address checks, dispatch
                    c_reg     <= drd_reg;
                    neg_reg   <= a_reg[31] ^ b_reg[31];
                    state_reg <= S_FIN;
                    if (err_reg == ERR_OK)
                    begin
                        if ((cmd_reg == CMD_DIV || cmd_reg == CMD_MOD) && b_reg == 0)
                            err_reg <= ERR_DIV0;
                        else if ((cmd_reg == CMD_STORE || cmd_reg == CMD_FETCH)
                                 && !addr_ok)
                            err_reg <= ERR_ADDR;
                        else if (cmd_reg == CMD_MUL)
                        begin
                            acc_reg   <= 64'(mag_a) * 64'(mag_b[15:0]);
                            state_reg <= S_MUL;
                        end
                        else if (cmd_reg == CMD_DIV || cmd_reg == CMD_MOD)
                        begin
                            rem_reg   <= '0;
                            dq_reg    <= (cmd_reg == CMD_DIV) ? {16'd0, mag_a, 16'd0}
                                                              : {mag_a, 32'd0};
                            den_reg   <= 64'(mag_b);
                            cnt_reg   <= (cmd_reg == CMD_DIV) ? 7'd64 : 7'd32;
                            state_reg <= S_DIV;
                        end
                    end
                end
                S_MUL:
                begin
                    acc_reg   <= acc_reg + ((64'(mag_a) * 64'(mag_b[31:16])) << 16);
                    state_reg <= S_FIN;
                end
                S_DIV:
                begin
                    // restoring divide, one quotient bit per cycle
                    if (trial >= den_reg)
                    begin
                        rem_reg <= trial - den_reg;
                        dq_reg  <= {dq_reg[62:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= trial;
                        dq_reg  <= {dq_reg[62:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg - 7'd1;
                    if (cnt_reg == 7'd1) state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    unique case (cmd_reg)
                        CMD_MUL, CMD_DIV: r_reg <= sat_res;
                        CMD_MOD: r_reg <= a_reg[31] ? -32'(rem_reg) : 32'(rem_reg);
                        CMD_LIT: r_reg <= lit_reg;
                        CMD_DUP: r_reg <= b_reg;
                        CMD_OVER: r_reg <= a_reg;
                        CMD_RFROM, CMD_RFETCH: r_reg <= rrd_reg;
                        CMD_I, CMD_J, CMD_K: r_reg <= {lrd_reg, 16'd0};
                        default: r_reg <= alu;
                    endcase
                    state_reg <= (err_reg == ERR_OK) ? S_WB0 : S_DONE;
                end
                S_WB0:
                begin
                    if (cmd_reg == CMD_POPOUT) rv_reg <= b_reg;
                    state_reg <= S_WB1;
                end
                S_WB1:
                    state_reg <= S_WB2;
                S_WB2:
                begin
                    // commit pointers
                    unique case (cmd_reg)
                        CMD_LIT, CMD_DUP, CMD_OVER, CMD_I, CMD_J, CMD_K,
                        CMD_RFETCH:
                            dp_reg <= dp_reg + DP_W'(1);
                        CMD_RFROM:
                        begin
                            dp_reg <= dp_reg + DP_W'(1);
                            rp_reg <= rp_reg - RP_W'(1);
                        end
                        CMD_TOR:
                        begin
                            dp_reg <= dp_reg - DP_W'(1);
                            rp_reg <= rp_reg + RP_W'(1);
                        end
                        CMD_DROP, CMD_POPOUT: dp_reg <= dp_reg - DP_W'(1);
                        CMD_STORE: dp_reg <= dp_reg - DP_W'(2);
                        CMD_LENTER: lp_reg <= lp_reg + LP_W'(1);
                        CMD_LLEAVE: lp_reg <= lp_reg - LP_W'(1);
                        default:
                            if (cmd_reg >= CMD_ADD && cmd_reg <= CMD_OR)
                                dp_reg <= dp_reg - DP_W'(1);
                    endcase
                    state_reg <= S_DONE;
                end
                S_DONE:
                    if (out_load)
                    begin
                        out_reg.out_value  <= rv_reg;
                        out_reg.out_valid  <= (cmd_reg == CMD_POPOUT) && (err_reg == ERR_OK);
                        out_reg.error_code <= err_reg;
                        out_reg.depth_now  <= 7'(dp_reg);
                        state_reg          <= S_IDLE;
                    end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_dp_range: assert property (@(posedge clk) disable iff (!rst_n)
        dp_reg <= DP_W'(STACK_DEPTH)) else $error("data pointer beyond depth");
    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLEAR |-> !in_ch.ready) else $error("accept during clear");
    a_err_keeps_dp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && err_reg != ERR_OK) |=> $stable(dp_reg))
        else $error("error changed pointer");
    a_valid_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.data.out_valid |-> out_ch.data.error_code == ERR_OK)
        else $error("popped value with error");
`endif

endmodule

### tb/sv/smeu_scoreboard.sv
// ----------------------------------------------------------------------------
// smeu_scoreboard
// Watches both channels of the execute unit, predicts each result from its
// own copy of the stacks and memory, and compares it field by field.
// ----------------------------------------------------------------------------
module smeu_scoreboard
    import smeu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_ready,
    input  smeu_in_t  in_data,
    input  logic      out_valid,
    input  logic      out_ready,
    input  smeu_out_t out_data,
    output int        fail_count,
    output int        result_count,
    output int        error_count,
    output int        popout_count,
    output int        pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint ONE_Q = 65536;

    logic signed [31:0] data_stk [STACK_DEPTH];
    logic signed [31:0] ret_stk  [RSTACK_DEPTH];
    logic signed [15:0] loop_stk [LOOP_DEPTH];
    logic signed [31:0] data_mem [MEM_DEPTH];
    int unsigned        dptr;
    int unsigned        rptr;
    int unsigned        lptr;

    smeu_out_t expected_results[$];

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // check operand count and room on the data stack
    function automatic err_t data_room(int unsigned need, int unsigned grow);
        if (dptr < need)
            return ERR_UNDER;
        if (dptr + grow > STACK_DEPTH)
            return ERR_OVER;
        return ERR_OK;
    endfunction

    function automatic logic addr_valid(logic signed [31:0] raw);
        return (raw >= 0) && (longint'(raw) < longint'(MEM_DEPTH) * ONE_Q);
    endfunction

    // run one primitive on the local state and return its result
    function automatic smeu_out_t execute_primitive(smeu_in_t prim);
        smeu_out_t   res;
        err_t        err;
        longint      a;
        longint      b;
        longint      r;
        int unsigned lvl;
        logic signed [31:0] t0;
        logic signed [31:0] t1;
        logic signed [31:0] t2;
        res = '0;
        err = ERR_OK;
        r   = 0;
        if (prim.cmd >= CMD_ADD && prim.cmd <= CMD_OR) begin
            err = data_room(2, 0);
            if (err == ERR_OK) begin
                b = data_stk[dptr-1];
                a = data_stk[dptr-2];
                case (prim.cmd)
                    CMD_ADD: r = sat32(a + b);
                    CMD_SUB: r = sat32(a - b);
                    CMD_MUL: r = sat32((a * b) / ONE_Q);
                    CMD_DIV:
                        if (b == 0)
                            err = ERR_DIV0;
                        else
                            r = sat32((a * ONE_Q) / b);
                    CMD_MOD:
                        if (b == 0)
                            err = ERR_DIV0;
                        else
                            r = a % b;
                    CMD_EQ:  r = (a == b) ? ONE_Q : 0;
                    CMD_LT:  r = (a < b) ? ONE_Q : 0;
                    CMD_GT:  r = (a > b) ? ONE_Q : 0;
                    CMD_AND: r = ((a / ONE_Q) & (b / ONE_Q)) * ONE_Q;
                    default: r = ((a / ONE_Q) | (b / ONE_Q)) * ONE_Q;
                endcase
                if (err == ERR_OK) begin
                    dptr = dptr - 1;
                    data_stk[dptr-1] = r[31:0];
                end
            end
        end
        else begin
            case (prim.cmd)
                CMD_LIT: begin
                    err = data_room(0, 1);
                    if (err == ERR_OK) begin
                        data_stk[dptr] = prim.literal;
                        dptr = dptr + 1;
                    end
                end
                CMD_NOT: begin
                    err = data_room(1, 0);
                    if (err == ERR_OK)
                        data_stk[dptr-1] = (data_stk[dptr-1] == 0) ? 32'sd65536 : 32'sd0;
                end
                CMD_DUP: begin
                    err = data_room(1, 1);
                    if (err == ERR_OK) begin
                        data_stk[dptr] = data_stk[dptr-1];
                        dptr = dptr + 1;
                    end
                end
                CMD_DROP: begin
                    err = data_room(1, 0);
                    if (err == ERR_OK)
                        dptr = dptr - 1;
                end
                CMD_SWAP: begin
                    err = data_room(2, 0);
                    if (err == ERR_OK) begin
                        t0 = data_stk[dptr-1];
                        data_stk[dptr-1] = data_stk[dptr-2];
                        data_stk[dptr-2] = t0;
                    end
                end
                CMD_OVER: begin
                    err = data_room(2, 1);
                    if (err == ERR_OK) begin
                        data_stk[dptr] = data_stk[dptr-2];
                        dptr = dptr + 1;
                    end
                end
                CMD_ROT: begin
                    err = data_room(3, 0);
                    if (err == ERR_OK) begin
                        t0 = data_stk[dptr-1];
                        t1 = data_stk[dptr-2];
                        t2 = data_stk[dptr-3];
                        data_stk[dptr-3] = t1;
                        data_stk[dptr-2] = t0;
                        data_stk[dptr-1] = t2;
                    end
                end
                CMD_TOR: begin
                    if (dptr < 1)
                        err = ERR_UNDER;
                    else if (rptr >= RSTACK_DEPTH)
                        err = ERR_ROVER;
                    else begin
                        ret_stk[rptr] = data_stk[dptr-1];
                        rptr = rptr + 1;
                        dptr = dptr - 1;
                    end
                end
                CMD_RFROM, CMD_RFETCH: begin
                    if (rptr < 1)
                        err = ERR_RUNDER;
                    else if (dptr >= STACK_DEPTH)
                        err = ERR_OVER;
                    else begin
                        data_stk[dptr] = ret_stk[rptr-1];
                        dptr = dptr + 1;
                        if (prim.cmd == CMD_RFROM)
                            rptr = rptr - 1;
                    end
                end
                CMD_STORE: begin
                    err = data_room(2, 0);
                    if (err == ERR_OK) begin
                        t0 = data_stk[dptr-1];
                        if (!addr_valid(t0))
                            err = ERR_ADDR;
                        else begin
                            data_mem[t0[31:16] % MEM_DEPTH] = data_stk[dptr-2];
                            dptr = dptr - 2;
                        end
                    end
                end
                CMD_FETCH: begin
                    err = data_room(1, 0);
                    if (err == ERR_OK) begin
                        t0 = data_stk[dptr-1];
                        if (!addr_valid(t0))
                            err = ERR_ADDR;
                        else
                            data_stk[dptr-1] = data_mem[t0[31:16] % MEM_DEPTH];
                    end
                end
                CMD_I, CMD_J, CMD_K: begin
                    lvl = prim.cmd - 21;
                    if (lptr < lvl)
                        err = ERR_NOLOOP;
                    else if (dptr >= STACK_DEPTH)
                        err = ERR_OVER;
                    else begin
                        data_stk[dptr] = {loop_stk[lptr-lvl], 16'h0000};
                        dptr = dptr + 1;
                    end
                end
                CMD_POPOUT: begin
                    err = data_room(1, 0);
                    if (err == ERR_OK) begin
                        res.out_value = data_stk[dptr-1];
                        res.out_valid = 1'b1;
                        dptr = dptr - 1;
                    end
                end
                CMD_LENTER: begin
                    if (lptr >= LOOP_DEPTH)
                        err = ERR_LOVER;
                    else begin
                        loop_stk[lptr] = prim.literal[15:0];
                        lptr = lptr + 1;
                    end
                end
                CMD_LLEAVE: begin
                    if (lptr < 1)
                        err = ERR_NOLOOP;
                    else
                        lptr = lptr - 1;
                end
                default: ;
            endcase
        end
        res.error_code = err;
        res.depth_now  = dptr[6:0];
        return res;
    endfunction

    assign pending = expected_results.size();

    // predict on accepted primitives, compare on accepted results
    always @(posedge clk or negedge rst_n)
    begin
        smeu_out_t want;
        if (!rst_n) begin
            dptr = 0;
            rptr = 0;
            lptr = 0;
            foreach (data_mem[n])
                data_mem[n] = '0;
            expected_results.delete();
            fail_count   <= 0;
            result_count <= 0;
            error_count  <= 0;
            popout_count <= 0;
        end
        else begin
            if (in_valid && in_ready)
                expected_results = {expected_results, execute_primitive(in_data)};
            if (out_valid && out_ready) begin
                result_count <= result_count + 1;
                if (out_data.error_code != ERR_OK)
                    error_count <= error_count + 1;
                if (out_data.out_valid)
                    popout_count <= popout_count + 1;
                if (expected_results.size() == 0) begin
                    $error("result transaction with nothing expected");
                    fail_count <= fail_count + 1;
                end
                else begin
                    want = expected_results.pop_front();
                    if (out_data != want) begin
                        fail_count <= fail_count + 1;
                        if (out_data.out_value != want.out_value)
                            $error("out_value: expected %0d, got %0d",
                                   want.out_value, out_data.out_value);
                        if (out_data.out_valid != want.out_valid)
                            $error("out_valid: expected %0d, got %0d",
                                   want.out_valid, out_data.out_valid);
                        if (out_data.error_code != want.error_code)
                            $error("error_code: expected %0d, got %0d",
                                   want.error_code, out_data.error_code);
                        if (out_data.depth_now != want.depth_now)
                            $error("depth_now: expected %0d, got %0d",
                                   want.depth_now, out_data.depth_now);
                    end
                end
            end
        end
    end

endmodule

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives Forth primitives into the execute unit: a directed opening on the
// corner cases, then random primitive sequences (arithmetic, memory, loop,
// return stack, fill and drain runs, noise) with bursty input and stalling
// output. The scoreboard predicts and checks every result.
// ----------------------------------------------------------------------------
module tb_top;
    import smeu_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET = 550;
    localparam int CYCLE_LIMIT = 800000;
    localparam int DRAIN_WAIT  = 150;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   result_count;
    int   error_count;
    int   popout_count;
    int   pending;
    int   sent_count;
    int   cycle_count;
    int   burst_left;
    logic hold_off;
    int   stall_mode;

    smeu_stream_if #(.payload_t(smeu_in_t))  in_ch ();
    smeu_stream_if #(.payload_t(smeu_out_t)) out_ch ();

    stack_machine_execute_unit_top i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    smeu_scoreboard i_scoreboard (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_ch.valid),
        .in_ready     (in_ch.ready),
        .in_data      (in_ch.data),
        .out_valid    (out_ch.valid),
        .out_ready    (out_ch.ready),
        .out_data     (out_ch.data),
        .fail_count   (fail_count),
        .result_count (result_count),
        .error_count  (error_count),
        .popout_count (popout_count),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    // stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // hold off the output once for a long stretch
    initial
    begin
        hold_off = 1'b0;
        wait (sent_count >= 200);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (600) @(posedge clk);
        hold_off <= 1'b0;
    end

    // output stall pattern in one of three random modes
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
            stall_mode   <= 0;
        end
        else begin
            if (cycle_count % 64 == 0)
                stall_mode <= $urandom_range(0, 2);
            if (hold_off)
                out_ch.ready <= 1'b0;
            else if (stall_mode == 0)
                out_ch.ready <= 1'b1;
            else if (stall_mode == 1)
                out_ch.ready <= $urandom_range(0, 1);
            else
                out_ch.ready <= ($urandom_range(0, 3) == 0);
        end
    end

    // random Q16.16 operand, biased toward interesting values
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $urandom_range(0, 2) - 1;
            3: return $urandom();
            4: return {16'($urandom_range(0, 4095)), 16'h0000}
                      | 32'($urandom_range(0, 65535));
            default: return ($urandom_range(0, 64) - 32) * 65536 + $urandom_range(0, 3) * 16384;
        endcase
    endfunction

    function automatic logic signed [31:0] pick_addr();
        case ($urandom_range(0, 9))
            0: return 32'sh10000000;
            1: return -($urandom_range(1, 65536));
            2: return $urandom();
            default: return {4'h0, 12'($urandom_range(0, 4095)), 16'($urandom())};
        endcase
    endfunction

    // offer one primitive, with bursts and gaps, until accepted
    task automatic send(cmd_t op, logic signed [31:0] value);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 1) ? $urandom_range(1, 12) : 0;
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left  = burst_left - 1;
        in_ch.valid <= 1'b1;
        in_ch.data  <= '{cmd: op, literal: value};
        forever begin
            @(negedge clk);
            if (in_ch.ready) begin
                @(posedge clk);
                break;
            end
        end
        sent_count = sent_count + 1;
    endtask

    task automatic send_raw(logic [4:0] op, logic signed [31:0] value);
        send(cmd_t'(op), value);
    endtask

    initial
    begin
        int seg;
        int n;
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        sent_count  = 0;
        burst_left  = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);

        // directed: empty stack, saturation, divide by zero, bad addresses,
        // missing loop and return entries, unused command codes
        send(CMD_ADD, 0);
        send(CMD_LIT, 32'sh7fffffff);
        send(CMD_LIT, 32'sh7fffffff);
        send(CMD_ADD, 0);
        send(CMD_LIT, 0);
        send(CMD_DIV, 0);
        send(CMD_MOD, 0);
        send(CMD_DROP, 0);
        send(CMD_LIT, 32'sh80000000);
        send(CMD_MUL, 0);
        send(CMD_POPOUT, 0);
        send(CMD_RFROM, 0);
        send(CMD_I, 0);
        send(CMD_LLEAVE, 0);
        send(CMD_LENTER, 32'shffff8000);
        send(CMD_I, 0);
        send(CMD_LIT, 32'sh10000000);
        send(CMD_FETCH, 0);
        send(CMD_LIT, -1);
        send(CMD_FETCH, 0);
        send_raw(5'd31, 32'sh5a5a5a5a);
        send(CMD_TOR, 0);
        send(CMD_RFETCH, 0);
        send(CMD_ROT, 0);
        send(CMD_LLEAVE, 0);

        // random sequences
        while (sent_count < ITEM_TARGET) begin
            seg = $urandom_range(0, 19);
            if (seg < 6) begin
                send(CMD_LIT, pick_value());
                send(CMD_LIT, pick_value());
                send(cmd_t'($urandom_range(CMD_ADD, CMD_OR)), pick_value());
                if ($urandom_range(0, 1))
                    send(cmd_t'($urandom_range(CMD_NOT, CMD_ROT)), 0);
                send(CMD_POPOUT, 0);
            end
            else if (seg < 9) begin
                send(CMD_LIT, pick_value());
                send(CMD_LIT, pick_addr());
                send(CMD_STORE, 0);
                send(CMD_LIT, pick_addr());
                send(CMD_FETCH, 0);
                send(CMD_POPOUT, 0);
            end
            else if (seg < 12) begin
                n = $urandom_range(1, 4);
                repeat (n) send(CMD_LENTER, $urandom());
                send(cmd_t'($urandom_range(CMD_I, CMD_K)), 0);
                send(CMD_POPOUT, 0);
                repeat (n) send(CMD_LLEAVE, 0);
            end
            else if (seg < 14) begin
                send(CMD_LIT, pick_value());
                send(CMD_TOR, 0);
                send(cmd_t'($urandom_range(CMD_RFROM, CMD_RFETCH)), 0);
                send(CMD_POPOUT, 0);
            end
            else if (seg == 14) begin
                // fill the data stack past its depth, then drain it
                repeat (STACK_DEPTH + 2) send(CMD_LIT, pick_value());
                repeat (STACK_DEPTH + 2) send(CMD_POPOUT, 0);
            end
            else if (seg == 15) begin
                // overrun the return stack and the loop stack, then unwind
                repeat (RSTACK_DEPTH + 2) begin
                    send(CMD_LIT, pick_value());
                    send(CMD_TOR, 0);
                end
                repeat (LOOP_DEPTH + 2) send(CMD_LENTER, $urandom());
                send(CMD_K, 0);
                repeat (LOOP_DEPTH + 2) send(CMD_LLEAVE, 0);
                repeat (RSTACK_DEPTH + 2) send(CMD_RFROM, 0);
                repeat (RSTACK_DEPTH + 4) send(CMD_POPOUT, 0);
            end
            else begin
                // noise
                repeat ($urandom_range(1, 6))
                    send_raw(5'($urandom_range(0, 31)), $urandom());
            end
        end

        @(posedge clk);
        in_ch.valid <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
        $display("Sent %0d primitives, checked %0d results (%0d with error codes, %0d popouts)",
                 sent_count, result_count, error_count, popout_count);
        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
